FILE: src/tlik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, codes, constants and the CORDIC arctangent table for the
// two-link leg inverse kinematics solver.
// ----------------------------------------------------------------------------
package tlik_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;

    localparam int COORD_W    = 12;
    localparam int LINK_W     = 11;
    localparam int HIP_W      = 17;
    localparam int KNEE_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LINK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLVER_RDY = 2'd2;

    localparam logic [LINK_W-1:0] LINK_RESET = 11'd1000;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLAMPED   = 2'd2;

    localparam int CORDIC_STEPS = 26;
    localparam int PRESCALE     = 24;
    localparam int CORDIC_W     = 54;
    localparam int Z_W          = 34;
    localparam int ANG30_W      = 32;
    localparam int N_W          = 27;
    localparam int MUL_W        = 26;
    localparam int PROD_W       = 52;
    localparam int SQRT_IN_W    = 50;
    localparam int SQRT_OUT_W   = 25;

    localparam longint PI_Q30         = 64'd3373259426;
    localparam longint TWO_PI_Q30     = 64'd6746518852;
    localparam longint QUARTER_PI_Q30 = 64'd843314857;
    localparam longint HALF_PI_Q30    = 64'd1686629713;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_SQRT,
        ST_ATAN,
        ST_CAND,
        ST_PICK,
        ST_OUT
    } tlik_state_t;

    typedef enum logic [1:0] {
        PH_KNEE,
        PH_PSI,
        PH_THETA
    } tlik_phase_t;

    localparam logic [3:0] OP_XX   = 4'd0;
    localparam logic [3:0] OP_YY   = 4'd1;
    localparam logic [3:0] OP_L1SQ = 4'd2;
    localparam logic [3:0] OP_L2SQ = 4'd3;
    localparam logic [3:0] OP_L1L2 = 4'd4;
    localparam logic [3:0] OP_SUM  = 4'd5;
    localparam logic [3:0] OP_DIFF = 4'd6;
    localparam logic [3:0] OP_NSQK = 4'd7;
    localparam logic [3:0] OP_DSQK = 4'd8;
    localparam logic [3:0] OP_NSQP = 4'd9;
    localparam logic [3:0] OP_DSQP = 4'd10;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            5'd24:   v = 30'd64;
            5'd25:   v = 30'd32;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/tlik_target_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_target_if
// Request channel carrying one foot target.
// ----------------------------------------------------------------------------
interface tlik_target_if;
    logic                          valid;
    logic                          ready;
    logic [tlik_pkg::COORD_W-1:0]  target_x;
    logic [tlik_pkg::COORD_W-1:0]  target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface
`default_nettype wire

FILE: src/tlik_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_result_if
// Result channel carrying hip angle, knee angle and status.
// ----------------------------------------------------------------------------
interface tlik_result_if;
    logic                           valid;
    logic                           ready;
    logic signed [tlik_pkg::HIP_W-1:0] hip_angle;
    logic [tlik_pkg::KNEE_W-1:0]    knee_angle;
    logic [tlik_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output hip_angle, output knee_angle, output status,
                    input ready);
    modport sink   (input valid, input hip_angle, input knee_angle, input status,
                    output ready);
endinterface
`default_nettype wire

FILE: src/tlik_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_isqrt
// Floor square root, two radicand bits per cycle, restoring digit recurrence.
// ----------------------------------------------------------------------------
module tlik_isqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tlik_pkg::SQRT_IN_W-1:0]   radicand,
    output logic                             done,
    output logic [tlik_pkg::SQRT_OUT_W-1:0]  root
);
    import tlik_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              cnt_reg;
    logic [SQRT_IN_W-1:0]    v_reg;
    logic [SQRT_OUT_W:0]     rem_reg;
    logic [SQRT_OUT_W-1:0]   root_reg;

    logic [SQRT_OUT_W+2:0]   rem_shift;
    logic [SQRT_OUT_W+2:0]   trial;
    logic [SQRT_OUT_W+2:0]   rem_sub;
    logic                    fits;

    always_comb
    begin
        rem_shift = {rem_reg, v_reg[SQRT_IN_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
        rem_sub   = rem_shift - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[SQRT_IN_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sub[SQRT_OUT_W:0];
                root_reg <= {root_reg[SQRT_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[SQRT_OUT_W:0];
                root_reg <= {root_reg[SQRT_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

FILE: src/tlik_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_cordic
// Vectoring CORDIC for atan2(y, x) with y >= 0, one micro-rotation per cycle,
// result in Q2.30 over 0..pi.
// ----------------------------------------------------------------------------
module tlik_cordic
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tlik_pkg::SQRT_OUT_W-1:0]   y_in,
    input  logic signed [tlik_pkg::N_W-1:0]   x_in,
    output logic                              done,
    output logic [tlik_pkg::ANG30_W-1:0]      angle
);
    import tlik_pkg::*;

    localparam logic [ANG30_W-1:0] PI_Z   = ANG30_W'(PI_Q30);
    localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(HALF_PI_Q30);

    logic                        busy_reg;
    logic                        fin_reg;
    logic                        done_reg;
    logic [4:0]                  step_reg;
    logic                        neg_reg;
    logic signed [CORDIC_W-1:0]  cx_reg;
    logic signed [CORDIC_W-1:0]  cy_reg;
    logic signed [Z_W-1:0]       z_reg;
    logic [ANG30_W-1:0]          angle_reg;

    logic [N_W-1:0]              x_abs;
    logic [CORDIC_W-1:0]         x_ext;
    logic [CORDIC_W-1:0]         y_ext;
    logic signed [CORDIC_W-1:0]  dx;
    logic signed [CORDIC_W-1:0]  dy;
    logic signed [Z_W-1:0]       z_step;
    logic signed [Z_W-1:0]       z_clip;

    always_comb
    begin
        x_abs  = x_in[N_W-1] ? N_W'(-x_in) : N_W'(x_in);
        x_ext  = CORDIC_W'(x_abs) << PRESCALE;
        y_ext  = CORDIC_W'(y_in) << PRESCALE;
        dx     = cy_reg >>> step_reg;
        dy     = cx_reg >>> step_reg;
        z_step = Z_W'(atan_q30(step_reg));
        priority if (z_reg < 0)
            z_clip = '0;
        else if (z_reg > HALF_Z)
            z_clip = HALF_Z;
        else
            z_clip = z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if (y_in == '0)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == 5'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= x_in[N_W-1];
            cx_reg    <= signed'(x_ext);
            cy_reg    <= signed'(y_ext);
            z_reg     <= '0;
            angle_reg <= x_in[N_W-1] ? PI_Z : '0;
        end
        else if (busy_reg)
        begin
            if (!cy_reg[CORDIC_W-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + z_step;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - z_step;
            end
        end
        else if (fin_reg)
        begin
            angle_reg <= neg_reg ? (PI_Z - ANG30_W'(z_clip)) : ANG30_W'(z_clip);
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule
`default_nettype wire

FILE: src/two_link_leg_inverse_kinematics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics_top
// Hip and knee angles for a two-link planar leg from a foot target.
// ----------------------------------------------------------------------------
// One target is solved at a time; the block takes a new target once the
// previous one has moved into the result register. A solve runs the
// shared 26x26 multiplier for the squares and products, then for each of
// the two arc-cosines a range check, a square root and a CORDIC, a third
// check and a CORDIC for the target direction, and then picks the hip
// candidate nearest the previous one and registers the result. The next
// target can be taken in the cycle after the result is registered. An
// arc-cosine whose argument falls out of range skips its square root and
// CORDIC. With the solver not ready the target goes from the idle state
// straight to the output state and the result carries zero angles.
// Angles are radians with ANGLE_FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module two_link_leg_inverse_kinematics_top
#(
    parameter int ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    tlik_target_if.sink                       target,
    tlik_result_if.source                     result,
    input  logic                              cfg_wr_en,
    input  logic [tlik_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlik_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tlik_pkg::*;

    localparam int AW = ANGLE_FRAC_BITS + 5;
    localparam int DW = ((AW > HIP_W) ? AW : HIP_W) + 2;
    localparam int RSH = 30 - ANGLE_FRAC_BITS;
    localparam longint RND = longint'(1) << (29 - ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] PI_A     = AW'((PI_Q30 + RND) >>> RSH);
    localparam logic signed [AW-1:0] TWO_PI_A = AW'((TWO_PI_Q30 + RND) >>> RSH);
    localparam logic [HIP_W-1:0] HIP_RESET = HIP_W'((QUARTER_PI_Q30 + RND) >>> RSH);

    function automatic logic signed [AW-1:0] to_angle(input logic [ANG30_W-1:0] z);
        logic [ANG30_W+1:0] t;
        t = {2'b00, z} + (ANG30_W+2)'(RND);
        return AW'(t[ANG30_W+1 -: ANGLE_FRAC_BITS + 4]);
    endfunction

    tlik_state_t state_reg, state_next;
    tlik_phase_t phase_reg;
    logic [3:0]  op_reg;

    logic [LINK_W-1:0] upper_reg;
    logic [LINK_W-1:0] lower_reg;
    logic              solver_ready_reg;

    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [23:0]         xx_reg;
    logic [23:0]         yy_reg;
    logic [21:0]         l1sq_reg;
    logic [21:0]         l2sq_reg;
    logic [21:0]         p12_reg;
    logic [24:0]         s_reg;
    logic signed [N_W-1:0] kn_reg;
    logic signed [N_W-1:0] pn_reg;
    logic [MUL_W-1:0]    knabs_reg;
    logic [MUL_W-1:0]    pnabs_reg;
    logic [PROD_W-1:0]   nsqk_reg;
    logic [PROD_W-1:0]   dsqk_reg;
    logic [PROD_W-1:0]   nsqp_reg;
    logic [PROD_W-1:0]   dsqp_reg;

    logic                clamp_reg;
    logic signed [AW-1:0] knee_acos_reg;
    logic signed [AW-1:0] psi_reg;
    logic signed [AW-1:0] theta_reg;
    logic signed [AW-1:0] c1_reg;
    logic signed [AW-1:0] c2_reg;
    logic signed [AW-1:0] knee_base_reg;
    logic signed [AW-1:0] knee_alt_reg;
    logic signed [HIP_W-1:0] last_hip_reg;

    logic [HIP_W-1:0]    res_hip_reg;
    logic [KNEE_W-1:0]   res_knee_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [HIP_W-1:0]    out_hip_reg;
    logic [KNEE_W-1:0]   out_knee_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    logic signed [N_W-1:0] kn_calc;
    logic signed [N_W-1:0] pn_calc;

    logic [PROD_W-1:0]   nsq_sel;
    logic [PROD_W-1:0]   dsq_sel;
    logic [PROD_W-1:0]   dsq_diff;
    logic signed [N_W-1:0] n_sel;
    logic                bad;
    logic signed [AW-1:0] clamp_angle;

    logic                accept;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [SQRT_OUT_W-1:0] sqrt_root;
    logic                cordic_start;
    logic                cordic_done;
    logic [ANG30_W-1:0]  cordic_angle;
    logic [SQRT_OUT_W-1:0] cordic_y;
    logic signed [N_W-1:0] cordic_x;
    logic signed [AW-1:0] angle_rnd;
    logic                load_out;
    logic                step_phase;

    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
    logic [DW-1:0]       d1_abs;
    logic [DW-1:0]       d2_abs;
    logic                take_first;
    logic signed [AW-1:0] hip_pick;
    logic signed [AW-1:0] knee_pick;

    // shared multiplier operands
    always_comb
    begin
        unique case (op_reg)
            OP_XX:   begin mul_a = MUL_W'(x_reg);     mul_b = MUL_W'(x_reg);     end
            OP_YY:   begin mul_a = MUL_W'(y_reg);     mul_b = MUL_W'(y_reg);     end
            OP_L1SQ: begin mul_a = MUL_W'(upper_reg); mul_b = MUL_W'(upper_reg); end
            OP_L2SQ: begin mul_a = MUL_W'(lower_reg); mul_b = MUL_W'(lower_reg); end
            OP_L1L2: begin mul_a = MUL_W'(upper_reg); mul_b = MUL_W'(lower_reg); end
            OP_NSQK: begin mul_a = knabs_reg;         mul_b = knabs_reg;         end
            OP_DSQK: begin mul_a = MUL_W'({p12_reg, 1'b0});
                           mul_b = MUL_W'({p12_reg, 1'b0});                     end
            OP_NSQP: begin mul_a = pnabs_reg;         mul_b = pnabs_reg;         end
            OP_DSQP: begin mul_a = MUL_W'(l1sq_reg);  mul_b = MUL_W'(s_reg);     end
            default: begin mul_a = '0;                mul_b = '0;                end
        endcase
        prod    = mul_a * mul_b;
        kn_calc = signed'(N_W'(l1sq_reg)) + signed'(N_W'(l2sq_reg)) - signed'(N_W'(s_reg));
        pn_calc = signed'(N_W'(l1sq_reg)) + signed'(N_W'(s_reg)) - signed'(N_W'(l2sq_reg));
    end

    // arc-cosine operand selection and range check
    always_comb
    begin
        if (phase_reg == PH_PSI)
        begin
            nsq_sel = nsqp_reg;
            dsq_sel = dsqp_reg;
            n_sel   = pn_reg;
        end
        else
        begin
            nsq_sel = nsqk_reg;
            dsq_sel = dsqk_reg;
            n_sel   = kn_reg;
        end
        dsq_diff    = dsq_sel - nsq_sel;
        bad         = (dsq_sel == '0) || (nsq_sel > dsq_sel);
        clamp_angle = n_sel[N_W-1] ? PI_A : '0;
        cordic_y    = (phase_reg == PH_THETA) ? SQRT_OUT_W'(y_reg) : sqrt_root;
        cordic_x    = (phase_reg == PH_THETA) ? signed'(N_W'(x_reg)) : n_sel;
        angle_rnd   = to_angle(cordic_angle);
    end

    // candidate selection
    always_comb
    begin
        d1         = DW'(c1_reg) - DW'(last_hip_reg);
        d2         = DW'(c2_reg) - DW'(last_hip_reg);
        d1_abs     = d1[DW-1] ? DW'(-d1) : DW'(d1);
        d2_abs     = d2[DW-1] ? DW'(-d2) : DW'(d2);
        take_first = (d1_abs < d2_abs);
        hip_pick   = take_first ? c1_reg : c2_reg;
        knee_pick  = take_first ? knee_base_reg : knee_alt_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = solver_ready_reg ? ST_MUL : ST_OUT;
            ST_MUL:
                if (op_reg == OP_DSQP)
                    state_next = ST_CHECK;
            ST_CHECK:
                if (phase_reg == PH_THETA)
                    state_next = ST_ATAN;
                else if (!bad)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (sqrt_done)
                    state_next = ST_ATAN;
            ST_ATAN:
                if (cordic_done)
                    state_next = (phase_reg == PH_THETA) ? ST_CAND : ST_CHECK;
            ST_CAND:
                state_next = ST_PICK;
            ST_PICK:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        target.ready = (state_reg == ST_IDLE);
        accept       = target.valid && target.ready;
        sqrt_start   = (state_reg == ST_CHECK) && (phase_reg != PH_THETA) && !bad;
        cordic_start = ((state_reg == ST_CHECK) && (phase_reg == PH_THETA)) ||
                       ((state_reg == ST_SQRT) && sqrt_done);
        step_phase   = ((state_reg == ST_CHECK) && (phase_reg != PH_THETA) && bad) ||
                       ((state_reg == ST_ATAN) && cordic_done);
        load_out     = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_KNEE;
            op_reg           <= OP_XX;
            upper_reg        <= LINK_RESET;
            lower_reg        <= LINK_RESET;
            solver_ready_reg <= 1'b1;
            clamp_reg        <= 1'b0;
            last_hip_reg     <= signed'(HIP_RESET);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_UPPER_LINK: upper_reg        <= cfg_data[LINK_W-1:0];
                    CFG_LOWER_LINK: lower_reg        <= cfg_data[LINK_W-1:0];
                    CFG_SOLVER_RDY: solver_ready_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                op_reg    <= OP_XX;
                phase_reg <= PH_KNEE;
                clamp_reg <= 1'b0;
            end
            if (state_reg == ST_MUL)
                op_reg <= op_reg + 4'd1;
            if ((state_reg == ST_CHECK) && (phase_reg != PH_THETA) && bad)
                clamp_reg <= 1'b1;
            if (step_phase)
            begin
                unique case (phase_reg)
                    PH_KNEE: phase_reg <= PH_PSI;
                    PH_PSI:  phase_reg <= PH_THETA;
                    default: phase_reg <= PH_KNEE;
                endcase
            end
            if (state_reg == ST_PICK)
                last_hip_reg <= signed'(HIP_W'(hip_pick));
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg          <= target.target_x;
            y_reg          <= target.target_y;
            res_hip_reg    <= '0;
            res_knee_reg   <= '0;
            res_status_reg <= STATUS_NOT_READY;
        end
        if (state_reg == ST_MUL)
        begin
            unique case (op_reg)
                OP_XX:   xx_reg   <= prod[23:0];
                OP_YY:   yy_reg   <= prod[23:0];
                OP_L1SQ: l1sq_reg <= prod[21:0];
                OP_L2SQ: l2sq_reg <= prod[21:0];
                OP_L1L2: p12_reg  <= prod[21:0];
                OP_SUM:  s_reg    <= 25'(xx_reg) + 25'(yy_reg);
                OP_DIFF:
                begin
                    kn_reg    <= kn_calc;
                    pn_reg    <= pn_calc;
                    knabs_reg <= kn_calc[N_W-1] ? MUL_W'(-kn_calc) : MUL_W'(kn_calc);
                    pnabs_reg <= pn_calc[N_W-1] ? MUL_W'(-pn_calc) : MUL_W'(pn_calc);
                end
                OP_NSQK: nsqk_reg <= prod;
                OP_DSQK: dsqk_reg <= prod;
                OP_NSQP: nsqp_reg <= prod;
                OP_DSQP: dsqp_reg <= {prod[PROD_W-3:0], 2'b00};
                default: ;
            endcase
        end
        if ((state_reg == ST_CHECK) && (phase_reg != PH_THETA) && bad)
        begin
            if (phase_reg == PH_KNEE)
                knee_acos_reg <= clamp_angle;
            else
                psi_reg <= clamp_angle;
        end
        if ((state_reg == ST_ATAN) && cordic_done)
        begin
            unique case (phase_reg)
                PH_KNEE:  knee_acos_reg <= angle_rnd;
                PH_PSI:   psi_reg       <= angle_rnd;
                default:  theta_reg     <= angle_rnd;
            endcase
        end
        if (state_reg == ST_CAND)
        begin
            c1_reg        <= theta_reg - psi_reg;
            c2_reg        <= theta_reg + psi_reg;
            knee_base_reg <= PI_A - knee_acos_reg;
            knee_alt_reg  <= TWO_PI_A - (PI_A - knee_acos_reg);
        end
        if (state_reg == ST_PICK)
        begin
            res_hip_reg    <= HIP_W'(hip_pick);
            res_knee_reg   <= KNEE_W'(knee_pick);
            res_status_reg <= clamp_reg ? STATUS_CLAMPED : STATUS_OK;
        end
        if (load_out)
        begin
            out_hip_reg    <= res_hip_reg;
            out_knee_reg   <= res_knee_reg;
            out_status_reg <= res_status_reg;
        end
    end

    tlik_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (dsq_diff[SQRT_IN_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    tlik_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    assign result.valid      = out_valid_reg;
    assign result.hip_angle  = signed'(out_hip_reg);
    assign result.knee_angle = out_knee_reg;
    assign result.status     = out_status_reg;

endmodule
`default_nettype wire

FILE: src/tlik_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlik_checker
// Port-level checks on the solver's request and result channels.
// ----------------------------------------------------------------------------
module tlik_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           t_valid,
    input  logic                           t_ready,
    input  logic                           r_valid,
    input  logic                           r_ready,
    input  logic [tlik_pkg::HIP_W-1:0]     hip,
    input  logic [tlik_pkg::KNEE_W-1:0]    knee,
    input  logic [tlik_pkg::STATUS_W-1:0]  status
);
    import tlik_pkg::*;

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(hip) && $stable(knee) && $stable(status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (status == STATUS_OK) || (status == STATUS_NOT_READY) ||
                    (status == STATUS_CLAMPED))
        else $error("undefined status code");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && (status == STATUS_NOT_READY) |-> (hip == '0) && (knee == '0))
        else $error("not-ready result carries angles");

    // one request at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        t_valid && t_ready |=> !t_ready)
        else $error("request taken while busy");

endmodule

bind two_link_leg_inverse_kinematics_top tlik_checker u_tlik_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .t_valid (target.valid),
    .t_ready (target.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .hip     (result.hip_angle),
    .knee    (result.knee_angle),
    .status  (result.status)
);
`default_nettype wire
